// ===== hw/rtl/range_count_and_clear_below_threshold_top_defines.svh =====
// Assertion macros shared by the RTL files of the range count-and-clear block.
`ifndef RANGE_COUNT_AND_CLEAR_BELOW_THRESHOLD_TOP_DEFINES_SVH
`define RANGE_COUNT_AND_CLEAR_BELOW_THRESHOLD_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcc assertion failed");

// Next-cycle implication, checked outside reset.
`define RCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcc assertion failed");

`endif

// ===== hw/rtl/rcc_pkg.sv =====
package rcc_pkg;

   localparam int DEPTH_DEFAULT   = 64;
   localparam int CELL_LIMIT      = 64;   // positions and bounds are 6 bits wide
   localparam int CMD_QUEUE_SLOTS = 2;

   localparam int IDX_W   = 6;
   localparam int VALUE_W = 31;
   localparam int COUNT_W = 7;
   localparam int GROUP_W = 8;            // match bits summed per first-stage adder
   localparam int GSUM_W  = 4;

   localparam logic [VALUE_W-1:0] EMPTY_VALUE = {VALUE_W{1'b1}};

   typedef enum logic {
      OP_SET   = 1'b0,
      OP_COUNT = 1'b1
   } op_type;

   typedef struct packed {
      op_type               kind;
      logic [IDX_W-1:0]     position;
      logic [VALUE_W-1:0]   operand;   // value for a set, threshold for a count
      logic [IDX_W-1:0]     lo;
      logic [IDX_W-1:0]     hi;        // already clipped to the last cell
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM_GROUPS,
      ST_SUM_TOTAL
   } back_state_type;

   function automatic int num_cells(input int depth);
      return (depth < CELL_LIMIT) ? depth : CELL_LIMIT;
   endfunction

endpackage

// ===== hw/rtl/rcc_front.sv =====
module rcc_front #(
   parameter int DEPTH = rcc_pkg::DEPTH_DEFAULT
) (
   input  logic                          req_op,
   input  logic [rcc_pkg::IDX_W-1:0]     req_position,
   input  logic [rcc_pkg::VALUE_W-1:0]   req_value,
   input  logic [rcc_pkg::IDX_W-1:0]     req_lo,
   input  logic [rcc_pkg::IDX_W-1:0]     req_hi,
   input  logic [rcc_pkg::VALUE_W-1:0]   req_threshold,
   input  logic                          accept,
   output logic                          cmd_push,
   output rcc_pkg::cmd_type              cmd
);
   import rcc_pkg::*;

   localparam int NumCells = num_cells(DEPTH);
   localparam logic [IDX_W-1:0] LastCell = IDX_W'(NumCells - 1);

   logic set_in_table;

   // A set beyond the stored cells is taken but never reaches the back end.
   assign set_in_table = {1'b0, req_position} < (IDX_W + 1)'(NumCells);

   always_comb begin
      cmd.kind     = op_type'(req_op);
      cmd.position = req_position;
      cmd.operand  = (req_op == OP_COUNT) ? req_threshold : req_value;
      cmd.lo       = req_lo;
      cmd.hi       = (req_hi > LastCell) ? LastCell : req_hi;
      cmd_push     = accept && ((req_op == OP_COUNT) || set_in_table);
   end

endmodule

// ===== hw/rtl/rcc_cmd_queue.sv =====
module rcc_cmd_queue #(
   parameter int SLOTS = rcc_pkg::CMD_QUEUE_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rcc_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output rcc_pkg::cmd_type  head_cmd
);
   import rcc_pkg::*;
   `include "range_count_and_clear_below_threshold_top_defines.svh"

   localparam int PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntW = $clog2(SLOTS + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(SLOTS - 1);

   cmd_type           slot_ff [SLOTS];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff,  count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CntW'(SLOTS));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RCC_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !full)
   `RCC_ASSERT_NOW(a_count_bounded, clock, reset, 1'b1, count_ff <= CntW'(SLOTS))
   `RCC_ASSERT_NEXT(a_pop_drains, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1)

endmodule

// ===== hw/rtl/rcc_back.sv =====
module rcc_back #(
   parameter int DEPTH = rcc_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  rcc_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rcc_pkg::COUNT_W-1:0]   rsp_match_count
);
   import rcc_pkg::*;
   `include "range_count_and_clear_below_threshold_top_defines.svh"

   localparam int NumCells  = num_cells(DEPTH);
   localparam int NumGroups = (NumCells + GROUP_W - 1) / GROUP_W;
   localparam int PadBits   = NumGroups * GROUP_W;

   back_state_type      state_ff, state_in;
   logic [VALUE_W-1:0]  cell_ff [NumCells];
   logic [VALUE_W-1:0]  cell_in [NumCells];
   logic [NumCells-1:0] match_ff, match_in;
   logic [GSUM_W-1:0]   gsum_ff [NumGroups];
   logic [GSUM_W-1:0]   gsum_in [NumGroups];
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PadBits-1:0]  match_pad;
   logic [COUNT_W-1:0]  total;
   logic                rsp_slot_free;

   assign match_pad       = PadBits'(match_ff);
   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_slot_free   = !rsp_valid_ff || rsp_pop;

   // Every cell compares itself against the broadcast threshold and range.
   always_comb begin
      for (int i = 0; i < NumCells; i++) begin
         match_in[i] = (IDX_W'(i) >= cmd.lo) && (IDX_W'(i) <= cmd.hi)
                       && (cell_ff[i] <= cmd.operand);
      end
   end

   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         gsum_in[g] = '0;
         for (int k = 0; k < GROUP_W; k++) begin
            gsum_in[g] = gsum_in[g] + GSUM_W'(match_pad[g*GROUP_W + k]);
         end
      end
      total = '0;
      for (int g = 0; g < NumGroups; g++) begin
         total = total + COUNT_W'(gsum_ff[g]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_count_in = rsp_count_ff;
      for (int i = 0; i < NumCells; i++) begin
         cell_in[i] = cell_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == OP_SET) begin
                  for (int i = 0; i < NumCells; i++) begin
                     if (cmd.position == IDX_W'(i)) begin
                        cell_in[i] = cmd.operand;
                     end
                  end
               end else begin
                  for (int i = 0; i < NumCells; i++) begin
                     if (match_in[i]) begin
                        cell_in[i] = EMPTY_VALUE;
                     end
                  end
                  state_in = ST_SUM_GROUPS;
               end
            end
         end
         ST_SUM_GROUPS: begin
            state_in = ST_SUM_TOTAL;
         end
         ST_SUM_TOTAL: begin
            // Hold the group sums until the result register can take the count.
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = total;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumCells; i++) begin
            cell_ff[i] <= EMPTY_VALUE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NumCells; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   // The group sums load only while the count's match bits are in match_ff.
   always_ff @(posedge clock) begin
      match_ff     <= match_in;
      rsp_count_ff <= rsp_count_in;
      if (state_ff == ST_SUM_GROUPS) begin
         for (int g = 0; g < NumGroups; g++) begin
            gsum_ff[g] <= gsum_in[g];
         end
      end
   end

   `RCC_ASSERT_NOW(a_pop_only_idle, clock, reset, cmd_pop, (state_ff == ST_IDLE) && cmd_valid)
   `RCC_ASSERT_NOW(a_rsp_from_total, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_SUM_TOTAL))
   `RCC_ASSERT_NEXT(a_wait_for_slot, clock, reset, (state_ff == ST_SUM_TOTAL) && !rsp_slot_free, (state_ff == ST_SUM_TOTAL) && $stable(rsp_count_ff))

endmodule

// ===== hw/rtl/range_count_and_clear_below_threshold_top.sv =====
// Range count-and-clear over a table of values that reset fills with the
// all-ones empty marker.
// Request queue: drive req_* and push; the transaction is taken at a clock edge
// with push high and full low. op set writes value at position and returns
// nothing (positions past the table are dropped); op count returns how many
// entries in lo..hi hold a value at or below threshold and resets them to empty.
// Response queue: while empty is low, rsp_match_count shows the oldest count;
// it is taken at a clock edge with pop high.
// A two-entry command queue separates the request side from the execution
// side, so requests keep flowing while a count waits to be popped.
// A set is written in the idle state alone. A count runs through the
// parallel compare-and-clear, then two adder-tree stages; its response is
// loaded into the response register at the end of the second stage.
// While the response register is full and not popped, the final adder stage
// holds and later commands wait in the command queue; full rises once it fills.
// Synchronous reset empties both queues and returns every entry to empty at once.
module range_count_and_clear_below_threshold_top #(
   parameter int DEPTH = rcc_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_op,
   input  logic [rcc_pkg::IDX_W-1:0]     req_position,
   input  logic [rcc_pkg::VALUE_W-1:0]   req_value,
   input  logic [rcc_pkg::IDX_W-1:0]     req_lo,
   input  logic [rcc_pkg::IDX_W-1:0]     req_hi,
   input  logic [rcc_pkg::VALUE_W-1:0]   req_threshold,
   output logic                          empty,
   input  logic                          pop,
   output logic [rcc_pkg::COUNT_W-1:0]   rsp_match_count
);
   import rcc_pkg::*;

   logic    cmd_push;
   cmd_type cmd_in_q;
   cmd_type cmd_head;
   logic    cmd_head_valid;
   logic    cmd_pop;
   logic    accept;

   assign accept = push && !full;

   rcc_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .req_op        (req_op),
      .req_position  (req_position),
      .req_value     (req_value),
      .req_lo        (req_lo),
      .req_hi        (req_hi),
      .req_threshold (req_threshold),
      .accept        (accept),
      .cmd_push      (cmd_push),
      .cmd           (cmd_in_q)
   );

   rcc_cmd_queue #(
      .SLOTS(CMD_QUEUE_SLOTS)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_in_q),
      .full       (full),
      .pop        (cmd_pop),
      .head_valid (cmd_head_valid),
      .head_cmd   (cmd_head)
   );

   rcc_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_head_valid),
      .cmd             (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (empty),
      .rsp_pop         (pop),
      .rsp_match_count (rsp_match_count)
   );

endmodule

// ===== test/tb.sv =====
module tb;
   import rcc_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int COUNT_SAT   = (1 << COUNT_W) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_REQUESTS = 1150;

   typedef struct packed {
      op_type               kind;
      logic [IDX_W-1:0]     position;
      logic [VALUE_W-1:0]   value;
      logic [IDX_W-1:0]     lo;
      logic [IDX_W-1:0]     hi;
      logic [VALUE_W-1:0]   threshold;
      logic                 has_fixed;
      logic [COUNT_W-1:0]   fixed_count;
   } request_type;

   // kind, position, value, lo, hi, threshold, has_fixed, fixed_count
   localparam request_type DIRECTED_ROWS [23] = '{
      // Untouched slots hold the empty marker and still match a maximal threshold.
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd63, EMPTY_VALUE,  1'b1, 7'd64},
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd63, 31'h0,        1'b1, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd63, 6'd0,  EMPTY_VALUE,  1'b1, 7'd0},
      '{OP_SET,   6'd0,  31'h0,        6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_SET,   6'd63, 31'h7FFFFFFE, 6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_SET,   6'd21, 31'h2AAAAAAA, 6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_SET,   6'd42, 31'h55555555, 6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd0,  31'h0,        1'b1, 7'd1},
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd0,  31'h0,        1'b1, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd63, 6'd63, 31'h7FFFFFFE, 1'b1, 7'd1},
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd63, 31'h55555554, 1'b1, 7'd1},
      '{OP_COUNT, 6'd0,  31'h0,        6'd42, 6'd42, 31'h55555555, 1'b1, 7'd1},
      '{OP_SET,   6'd5,  31'd100,      6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_SET,   6'd6,  31'd101,      6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd6,  6'd5,  EMPTY_VALUE,  1'b1, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd5,  6'd6,  31'd100,      1'b1, 7'd1},
      '{OP_COUNT, 6'd0,  31'h0,        6'd5,  6'd6,  EMPTY_VALUE,  1'b1, 7'd2},
      '{OP_SET,   6'd33, EMPTY_VALUE,  6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd0,  6'd63, 31'h7FFFFFFE, 1'b1, 7'd0},
      '{OP_SET,   6'd63, 31'h0,        6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_SET,   6'd62, 31'd7,        6'd0,  6'd0,  31'h0,        1'b0, 7'd0},
      '{OP_COUNT, 6'd0,  31'h0,        6'd62, 6'd63, 31'd6,        1'b1, 7'd1},
      '{OP_COUNT, 6'd0,  31'h0,        6'd32, 6'd63, EMPTY_VALUE,  1'b1, 7'd32}
   };

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic                 req_op = 1'b0;
   logic [IDX_W-1:0]     req_position = '0;
   logic [VALUE_W-1:0]   req_value = '0;
   logic [IDX_W-1:0]     req_lo = '0;
   logic [IDX_W-1:0]     req_hi = '0;
   logic [VALUE_W-1:0]   req_threshold = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [COUNT_W-1:0]   rsp_match_count;

   logic [VALUE_W-1:0]   shadow_entries [TABLE_DEPTH];
   logic [COUNT_W-1:0]   expected_counts [$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   int                   burst_left = 0;
   int                   stall_left = 0;
   int                   pop_mode = 0;
   int                   pop_mode_left = 0;

   range_count_and_clear_below_threshold_top #(.DEPTH(TABLE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_value       (req_value),
      .req_lo          (req_lo),
      .req_hi          (req_hi),
      .req_threshold   (req_threshold),
      .empty           (empty),
      .pop             (pop),
      .rsp_match_count (rsp_match_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void report_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s", cycle_count, detail);
      end
   endfunction

   // Values cluster around small numbers and the empty marker so that
   // thresholds land on both sides of stored entries.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: v = VALUE_W'($urandom());
         3, 4, 5, 6: v = VALUE_W'($urandom_range(0, 63));
         7: v = EMPTY_VALUE;
         8: v = EMPTY_VALUE - VALUE_W'($urandom_range(0, 3));
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic request_type random_request();
      request_type req;
      int a;
      int b;
      int lower;
      int upper;
      int shape;
      a = $urandom_range(0, TABLE_DEPTH - 1);
      b = $urandom_range(0, TABLE_DEPTH - 1);
      lower = (a < b) ? a : b;
      upper = (a < b) ? b : a;
      shape = $urandom_range(0, 9);
      req.kind = ($urandom_range(0, 99) < 55) ? OP_SET : OP_COUNT;
      req.position = IDX_W'($urandom());
      req.value = random_value();
      req.threshold = random_value();
      if (shape < 2) begin
         req.lo = '0;
         req.hi = IDX_W'(TABLE_DEPTH - 1);
      end else if (shape == 2) begin
         // Reversed bounds: an empty range unless both ends coincide.
         req.lo = IDX_W'(upper);
         req.hi = IDX_W'(lower);
      end else if (shape < 6) begin
         req.lo = IDX_W'(lower);
         upper = lower + $urandom_range(0, 7);
         req.hi = IDX_W'((upper > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : upper);
      end else begin
         req.lo = IDX_W'(lower);
         req.hi = IDX_W'(upper);
      end
      req.has_fixed = 1'b0;
      req.fixed_count = '0;
      return req;
   endfunction

   // Called at a falling edge; returns at a falling edge after the transaction.
   task automatic send_request(input request_type req);
      int gap;
      int idx;
      int top;
      logic [COUNT_W-1:0] hits;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_op        <= req.kind;
      req_position  <= req.position;
      req_value     <= req.value;
      req_lo        <= req.lo;
      req_hi        <= req.hi;
      req_threshold <= req.threshold;
      push          <= 1'b1;
      do @(posedge clock); while (full);
      if (req.kind == OP_SET) begin
         if (int'(req.position) < TABLE_DEPTH) begin
            shadow_entries[req.position] = req.value;
         end
      end else begin
         hits = '0;
         top = (int'(req.hi) > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(req.hi);
         for (idx = int'(req.lo); idx <= top; idx++) begin
            if (shadow_entries[idx] <= req.threshold) begin
               shadow_entries[idx] = EMPTY_VALUE;
               if (hits < COUNT_W'(COUNT_SAT)) begin
                  hits++;
               end
            end
         end
         expected_counts.push_back(req.has_fixed ? req.fixed_count : hits);
      end
      @(negedge clock);
   endtask

   // The receiver switches among a never-stalling mode, short frequent stalls
   // and rare long ones.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_mode_left == 0) begin
            pop_mode = $urandom_range(0, 2);
            pop_mode_left = $urandom_range(50, 300);
         end else begin
            pop_mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            case (pop_mode)
               0: stall_left = 0;
               1: stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
               default: stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : 0;
            endcase
            pop <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      logic [COUNT_W-1:0] want;
      if (!reset && pop && !empty) begin
         if (expected_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, match_count %0d",
                                      rsp_match_count));
         end else begin
            want = expected_counts.pop_front();
            if (rsp_match_count !== want) begin
               report_mismatch($sformatf("match_count expected %0d, got %0d",
                                         want, rsp_match_count));
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      foreach (shadow_entries[i]) begin
         shadow_entries[i] = EMPTY_VALUE;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ROWS[r]) begin
         send_request(DIRECTED_ROWS[r]);
      end
      repeat (RANDOM_REQUESTS) begin
         send_request(random_request());
      end
      push <= 1'b0;
      while (expected_counts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_front.sv
hw/rtl/rcc_cmd_queue.sv
hw/rtl/rcc_back.sv
hw/rtl/range_count_and_clear_below_threshold_top.sv
test/tb.sv
